FILE: src/apsr_pkg.sv
// Shared types and constants for the analog pad serial responder.
// Used by apsr_engine and analog_pad_serial_responder_core; no dependencies.
package apsr_pkg;

	// Item kinds carried on the input tuser.
	typedef enum logic [1:0] {
		FUNC_EXCHANGE = 2'd0,
		FUNC_WR_BTN   = 2'd1,
		FUNC_WR_AXIS  = 2'd2,
		FUNC_DESELECT = 2'd3
	} func_t;

	// Exchange phases of one poll packet.
	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_READY  = 4'd1,
		PH_ID_HI  = 4'd2,
		PH_BTN_LO = 4'd3,
		PH_BTN_HI = 4'd4,
		PH_STEER  = 4'd5,
		PH_AX_I   = 4'd6,
		PH_AX_II  = 4'd7,
		PH_AX_L   = 4'd8
	} phase_t;

	localparam logic [15:0] PAD_ID       = 16'h5A23;
	localparam logic [7:0]  SEL_BYTE     = 8'h01;
	localparam logic [7:0]  CMD_READ     = 8'h42;
	localparam logic [7:0]  IDLE_BYTE    = 8'hFF;
	localparam logic [7:0]  STEER_CENTER = 8'h80;
	localparam logic [15:0] ALL_RELEASED = 16'hFFFF;

	localparam int unsigned AXIS_COUNT = 4;

	// One input item.
	typedef struct packed {
		func_t       func;
		logic [7:0]  data_in;
		logic [15:0] button_word;
		logic [1:0]  axis_index;
		logic [7:0]  axis_value;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [7:0] reply;
		logic       ack;
	} result_t;

endpackage

FILE: src/apsr_engine.sv
// Pad state (phase, button word, axis bytes) and the per-item response logic.
// Depends on apsr_pkg.
module apsr_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  apsr_pkg::item_t  item,
	output apsr_pkg::result_t res,
	output apsr_pkg::phase_t phase
);
	import apsr_pkg::*;

	phase_t     phase_q;
	phase_t     phase_d;
	logic [15:0] mask_q;
	logic [7:0]  axis_q [AXIS_COUNT];
	result_t     res_d;

	// Response and next phase for the item currently offered.
	always_comb begin
		phase_d     = phase_q;
		res_d.reply = IDLE_BYTE;
		res_d.ack   = 1'b0;
		case (item.func)
			FUNC_EXCHANGE: begin
				res_d.ack = 1'b1;
				case (phase_q)
					PH_IDLE: begin
						if (item.data_in == SEL_BYTE) begin
							phase_d = PH_READY;
						end else begin
							res_d.ack = 1'b0;
						end
					end
					PH_READY: begin
						if (item.data_in == CMD_READ) begin
							res_d.reply = PAD_ID[7:0];
							phase_d     = PH_ID_HI;
						end else begin
							res_d.ack = 1'b0;
						end
					end
					PH_ID_HI: begin
						res_d.reply = PAD_ID[15:8];
						phase_d     = PH_BTN_LO;
					end
					PH_BTN_LO: begin
						res_d.reply = mask_q[7:0];
						phase_d     = PH_BTN_HI;
					end
					PH_BTN_HI: begin
						res_d.reply = mask_q[15:8];
						phase_d     = PH_STEER;
					end
					PH_STEER: begin
						res_d.reply = axis_q[0];
						phase_d     = PH_AX_I;
					end
					PH_AX_I: begin
						res_d.reply = axis_q[1];
						phase_d     = PH_AX_II;
					end
					PH_AX_II: begin
						res_d.reply = axis_q[2];
						phase_d     = PH_AX_L;
					end
					PH_AX_L: begin
						res_d.reply = axis_q[3];
						res_d.ack   = 1'b0;
						phase_d     = PH_IDLE;
					end
					default: begin
						res_d.ack = 1'b0;
						phase_d   = PH_IDLE;
					end
				endcase
			end
			FUNC_DESELECT: begin
				phase_d = PH_IDLE;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// State update when the item is taken into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			mask_q    <= ALL_RELEASED;
			axis_q[0] <= STEER_CENTER;
			axis_q[1] <= '0;
			axis_q[2] <= '0;
			axis_q[3] <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			if (item.func == FUNC_WR_BTN) begin
				mask_q <= item.button_word;
			end
			if (item.func == FUNC_WR_AXIS) begin
				axis_q[item.axis_index] <= item.axis_value;
			end
		end
	end

	assign res   = res_d;
	assign phase = phase_q;

endmodule

FILE: src/analog_pad_serial_responder_core.sv
// Top level of the analog pad serial responder: input register, response engine,
// result register. Depends on apsr_pkg and apsr_engine.
//
// Each input item yields exactly one result item. An item is held in the input
// register and is answered into the result register once that register is open,
// so one item can be taken every cycle while m_axis_tready does not stall the
// result register. The single response step (phase decode and a byte select)
// lies between the two registers. Exchange items answer the console byte by byte
// (0xFF to the select byte, then 0x23, 0x5A, the button word low and high, and the
// four axis bytes); write and deselect items return 0xFF without acknowledge.
module analog_pad_serial_responder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] data_in, [23:8] button_word, [25:24] axis_index, [33:26] axis_value
	input  logic [39:0] s_axis_tdata,
	// [1:0] func
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] reply
	output logic [7:0]  m_axis_tdata,
	// [0] ack
	output logic [0:0]  m_axis_tuser
);
	import apsr_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t out_q;
	result_t res;
	phase_t  phase;
	logic    out_open;
	logic    fire_s1;

	// The result register can take an item when empty or being drained.
	assign out_open      = !out_valid_q || m_axis_tready;
	assign fire_s1       = valid_s1 && out_open;
	assign s_axis_tready = !valid_s1 || out_open;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.func        <= func_t'(s_axis_tuser);
			item_s1.data_in     <= s_axis_tdata[7:0];
			item_s1.button_word <= s_axis_tdata[23:8];
			item_s1.axis_index  <= s_axis_tdata[25:24];
			item_s1.axis_value  <= s_axis_tdata[33:26];
		end
	end

	apsr_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_s1),
		.item   (item_s1),
		.res    (res),
		.phase  (phase)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_open) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_q.reply;
	assign m_axis_tuser[0] = out_q.ack;

	// Write and deselect items never acknowledge and always answer the idle byte.
	a_noexch_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && item_s1.func != FUNC_EXCHANGE |=>
		m_axis_tvalid && !m_axis_tuser[0] && m_axis_tdata == IDLE_BYTE)
		else $error("non-exchange item produced an answer");

	// A deselect item always leaves the pad in the idle phase.
	a_deselect_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && item_s1.func == FUNC_DESELECT |=> phase == PH_IDLE)
		else $error("deselect did not return to idle");

	// An empty input register never refuses an item.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input refused while input register empty");

endmodule
